// ===== src/pas_pkg.sv =====
`timescale 1ns / 1ps

package pas_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  typedef struct packed {
    logic        operation;
    logic [7:0]  proc_id;
    logic [7:0]  base_prio;
    logic [15:0] lifespan;
    logic [15:0] age_so_far;
    logic        current_blocked;
  } req_t;

  typedef struct packed {
    logic       run_valid;
    logic [7:0] run_id;
    logic       preempted;
    logic       rejected;
  } rsp_t;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // One ready-queue entry as held in a cell.
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [7:0]  base;
    logic [15:0] life;
    logic [15:0] age;
  } entry_t;

  // Best-so-far candidate that walks down the chain.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } token_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_ENQ,
    CMD_TICK
  } cmd_op_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cmd_op_t    op;
    logic       take;
    logic       preempt;
    entry_t     push;
    logic [7:0] prio_cap;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENQ,
    ST_SCAN,
    ST_APPLY
  } state_t;

  function automatic logic [7:0] aged(input logic [7:0] p, input logic [7:0] ceiling);
    return (p < ceiling) ? p + 8'd1 : p;
  endfunction

endpackage

// ===== src/priority_aging_scheduler.sv =====
`timescale 1ns / 1ps
// Channel    Dir  Handshake            Payload
// req        in   req_valid/req_ready  pas_pkg::req_t (enqueue or tick)
// rsp        out  rsp_valid/rsp_ready  pas_pkg::rsp_t (one per request)
// cfg        in   cfg_write            cfg_value = aging ceiling
//
// Enqueue: accept, then a tail insert into the cell chain.
// Tick: accept, then the best-candidate token walks the chain through a register
// in each cell, then an apply step does pick, aging and shift.
// rst (synchronous) empties the queue, stops the running process, sets the
// aging ceiling to 255. A stalled rsp holds the finishing step until the output
// register frees; a new request is taken while a result still waits there.

module priority_aging_scheduler #(
  parameter int QUEUE_DEPTH = pas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pas_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pas_pkg::rsp_t rsp,
  input  logic          cfg_write,
  input  logic [7:0]    cfg_value
);

  localparam int IW = $clog2(QUEUE_DEPTH);

  // Chain wiring: cell i looks at cell i-1 (prev) and cell i+1 (next).
  logic [QUEUE_DEPTH-1:0] valid_vec;
  pas_pkg::entry_t        entry_v   [QUEUE_DEPTH];
  pas_pkg::token_t        tok_v     [QUEUE_DEPTH];
  logic [IW-1:0]          tok_idx_v [QUEUE_DEPTH];

  pas_pkg::state_t state, state_next;
  pas_pkg::cmd_t   cmd;
  logic [IW-1:0]   cnt;
  pas_pkg::req_t   item;
  logic [7:0]      prio_cap;

  logic        running_valid;
  logic [7:0]  running_id;
  logic [7:0]  running_base_prio;
  logic [15:0] running_lifespan;
  logic [15:0] running_age;

  logic            accept;
  logic            out_free;
  logic            load_out;
  logic            do_apply;
  pas_pkg::rsp_t   rsp_next;
  pas_pkg::token_t best;
  logic [IW-1:0]   best_idx;
  logic            alive;
  logic            preempt;
  logic            take;
  logic            full;

  assign accept   = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;
  assign best     = tok_v[QUEUE_DEPTH-1];
  assign best_idx = tok_idx_v[QUEUE_DEPTH-1];
  assign full     = valid_vec[QUEUE_DEPTH-1];

  // Running age was already advanced when the tick was accepted.
  assign alive   = running_valid && !item.current_blocked &&
                   (running_age < running_lifespan);
  assign preempt = alive && best.valid && (best.entry.prio >= running_base_prio);
  assign take    = best.valid && (preempt || !alive);

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic            prev_valid;
      logic            next_valid;
      pas_pkg::entry_t next_entry;
      pas_pkg::token_t tok_in;
      logic [IW-1:0]   tok_in_idx;

      if (g == 0) begin : g_head
        assign prev_valid = 1'b1;
        assign tok_in     = '0;
        assign tok_in_idx = '0;
      end else begin : g_body
        assign prev_valid = valid_vec[g-1];
        assign tok_in     = tok_v[g-1];
        assign tok_in_idx = tok_idx_v[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign next_valid = 1'b0;
        assign next_entry = '0;
      end else begin : g_mid
        assign next_valid = valid_vec[g+1];
        assign next_entry = entry_v[g+1];
      end

      pas_cell #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX         (g)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .sel         (best_idx),
        .prev_valid  (prev_valid),
        .next_valid  (next_valid),
        .next_entry  (next_entry),
        .tok_in      (tok_in),
        .tok_in_idx  (tok_in_idx),
        .tok_out     (tok_v[g]),
        .tok_out_idx (tok_idx_v[g]),
        .valid       (valid_vec[g]),
        .entry       (entry_v[g])
      );
    end
  endgenerate

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pas_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (req.operation == pas_pkg::OP_TICK) ? pas_pkg::ST_SCAN
                                                           : pas_pkg::ST_ENQ;
        end
      end
      pas_pkg::ST_ENQ: begin
        if (out_free) state_next = pas_pkg::ST_IDLE;
      end
      pas_pkg::ST_SCAN: begin
        if (cnt == IW'(QUEUE_DEPTH - 1)) state_next = pas_pkg::ST_APPLY;
      end
      pas_pkg::ST_APPLY: begin
        if (out_free) state_next = pas_pkg::ST_IDLE;
      end
      default: state_next = pas_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and the broadcast to the chain.
  always_comb begin
    req_ready    = 1'b0;
    load_out     = 1'b0;
    do_apply     = 1'b0;
    cmd          = '0;
    cmd.op       = pas_pkg::CMD_NONE;
    cmd.prio_cap = prio_cap;
    unique case (state)
      pas_pkg::ST_IDLE: req_ready = 1'b1;
      pas_pkg::ST_ENQ: begin
        cmd.push.id   = item.proc_id;
        cmd.push.prio = item.base_prio;
        cmd.push.base = item.base_prio;
        cmd.push.life = item.lifespan;
        cmd.push.age  = item.age_so_far;
        if (out_free) begin
          load_out = 1'b1;
          cmd.op   = pas_pkg::CMD_ENQ;
        end
      end
      pas_pkg::ST_SCAN: ;
      pas_pkg::ST_APPLY: begin
        // the preempted process goes back at its base priority, aged once
        cmd.take      = take;
        cmd.preempt   = preempt;
        cmd.push.id   = running_id;
        cmd.push.prio = pas_pkg::aged(running_base_prio, prio_cap);
        cmd.push.base = running_base_prio;
        cmd.push.life = running_lifespan;
        cmd.push.age  = running_age;
        if (out_free) begin
          load_out = 1'b1;
          do_apply = 1'b1;
          cmd.op   = pas_pkg::CMD_TICK;
        end
      end
      default: ;
    endcase
  end

  // Result of the finishing step.
  always_comb begin
    rsp_next = '0;
    if (state == pas_pkg::ST_APPLY) begin
      rsp_next.run_valid = take || alive;
      rsp_next.run_id    = take ? best.entry.id : (alive ? running_id : 8'd0);
      rsp_next.preempted = preempt;
    end else begin
      rsp_next.run_valid = running_valid;
      rsp_next.run_id    = running_valid ? running_id : 8'd0;
      rsp_next.rejected  = full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= pas_pkg::ST_IDLE;
      cnt               <= '0;
      prio_cap          <= 8'hFF;
      rsp_valid         <= 1'b0;
      running_valid     <= 1'b0;
      running_id        <= 8'd0;
      running_base_prio <= 8'd0;
      running_lifespan  <= 16'd0;
      running_age       <= 16'd0;
    end else begin
      state <= state_next;
      if (cfg_write) prio_cap <= cfg_value;

      // count the cycles the token needs to reach the last cell
      if (accept) cnt <= '0;
      else if (state == pas_pkg::ST_SCAN) cnt <= cnt + 1'b1;

      if (load_out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;

      // advance the running process's age at tick accept, saturating
      if (accept && (req.operation == pas_pkg::OP_TICK) && running_valid &&
          !req.current_blocked && (running_age != 16'hFFFF)) begin
        running_age <= running_age + 16'd1;
      end

      if (do_apply) begin
        if (take) begin
          running_valid     <= 1'b1;
          running_id        <= best.entry.id;
          running_base_prio <= best.entry.base;
          running_lifespan  <= best.entry.life;
          running_age       <= best.entry.age;
        end else if (!alive) begin
          // drop the finished or blocked process
          running_valid     <= 1'b0;
          running_id        <= 8'd0;
          running_base_prio <= 8'd0;
          running_lifespan  <= 16'd0;
          running_age       <= 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= req;
    if (load_out) rsp <= rsp_next;
  end

`ifndef SYNTH
  // Occupied cells always form a prefix of the chain.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    &(~valid_vec[QUEUE_DEPTH-1:1] | valid_vec[QUEUE_DEPTH-2:0]))
    else $error("ready queue has a hole");

  // At most one entry joins the queue per cycle.
  a_grow: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      ($countones(valid_vec) <= $countones($past(valid_vec)) + 1))
    else $error("ready queue grew by more than one entry");

  // A preemption always leaves a process running.
  a_preempt_runs: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pas_pkg::CMD_TICK) && cmd.preempt |=> running_valid)
    else $error("preemption left no running process");

  // The chain is only updated when the result register can take the result.
  a_cmd_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != pas_pkg::CMD_NONE) |-> (!rsp_valid || rsp_ready))
    else $error("chain update while result register busy");
`endif

endmodule

// ===== src/pas_cell.sv =====
`timescale 1ns / 1ps

module pas_cell #(
  parameter int QUEUE_DEPTH = pas_pkg::QUEUE_DEPTH_DEF,
  parameter int IDX         = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pas_pkg::cmd_t                    cmd,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   sel,
  input  logic                             prev_valid,
  input  logic                             next_valid,
  input  pas_pkg::entry_t                  next_entry,
  input  pas_pkg::token_t                  tok_in,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   tok_in_idx,
  output pas_pkg::token_t                  tok_out,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   tok_out_idx,
  output logic                             valid,
  output pas_pkg::entry_t                  entry
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic            is_tail;
  logic            is_first_free;
  logic            shift;
  logic            src_valid;
  pas_pkg::entry_t src;
  pas_pkg::entry_t src_aged;
  logic            self_wins;

  assign is_tail       = valid && !next_valid;
  assign is_first_free = !valid && prev_valid;
  // close the gap left by the chosen entry
  assign shift         = cmd.take && (MY_IDX >= sel);
  assign src_valid     = shift ? next_valid : valid;
  assign src           = shift ? next_entry : entry;

  always_comb begin
    src_aged      = src;
    src_aged.prio = pas_pkg::aged(src.prio, cmd.prio_cap);
  end

  // strict compare keeps the earliest entry on a tie
  assign self_wins = valid && (!tok_in.valid || (entry.prio > tok_in.entry.prio));

  always_ff @(posedge clk) begin
    tok_out.entry <= self_wins ? entry : tok_in.entry;
    tok_out_idx   <= self_wins ? MY_IDX : tok_in_idx;
    if (rst) begin
      valid         <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= self_wins || tok_in.valid;
      case (cmd.op)
        pas_pkg::CMD_ENQ: begin
          if (is_first_free) valid <= 1'b1;
        end
        pas_pkg::CMD_TICK: begin
          if (cmd.preempt && is_tail) valid <= 1'b1;
          else valid <= src_valid;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pas_pkg::CMD_ENQ: begin
        if (is_first_free) entry <= cmd.push;
      end
      pas_pkg::CMD_TICK: begin
        if (cmd.preempt && is_tail) entry <= cmd.push;
        else entry <= src_aged;
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int QD             = pas_pkg::QUEUE_DEPTH_DEF;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int PHASE_ITEMS    = 150;

  // Expected results that can be read straight off the schedule
  localparam pas_pkg::rsp_t NOTHING_RUNS = '0;
  localparam pas_pkg::rsp_t FF_RUNS      = '{1'b1, 8'hFF, 1'b0, 1'b0};
  localparam pas_pkg::rsp_t FF_FULL      = '{1'b1, 8'hFF, 1'b0, 1'b1};
  localparam pas_pkg::rsp_t ZERO_PREEMPT = '{1'b1, 8'h00, 1'b1, 1'b0};
  localparam pas_pkg::rsp_t ONE_PREEMPT  = '{1'b1, 8'h01, 1'b1, 1'b0};

  typedef struct {
    logic          pinned;  // use the typed-in result instead of the predicted one
    pas_pkg::rsp_t want;
  } pinned_t;

  typedef struct {
    pas_pkg::req_t item;
    pinned_t       pin;
  } dir_row_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  pas_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  pas_pkg::rsp_t rsp;
  logic          cfg_write = 1'b0;
  logic [7:0]    cfg_value = 8'd0;

  // Scoreboard bookkeeping
  pas_pkg::rsp_t dispatch_q[$];
  pinned_t       pinned_q[$];
  dir_row_t      dir_rows[$];
  int            fail_count = 0;
  int            sent_count = 0;
  int            rsp_seen   = 0;
  int            quiet_cycles = 0;

  // Idle/stall controls shared between the stimulus and the receiver
  bit req_idle = 1'b1;
  bit rsp_idle = 1'b1;
  bit hold_rsp = 1'b0;

  // Shadow copy of the scheduler state
  int unsigned ready_n;
  logic [7:0]  ready_id[QD];
  logic [7:0]  ready_prio[QD];
  logic [7:0]  ready_base[QD];
  logic [15:0] ready_life[QD];
  logic [15:0] ready_age[QD];
  logic        cur_valid;
  logic [7:0]  cur_id;
  logic [7:0]  cur_base;
  logic [15:0] cur_life;
  logic [15:0] cur_age;
  logic [7:0]  ceiling;

  priority_aging_scheduler #(
    .QUEUE_DEPTH(QD)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_write(cfg_write),
    .cfg_value(cfg_value)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Raise a waiting priority by one; stop at the ceiling.
  function automatic logic [7:0] bump(logic [7:0] p);
    return (p < ceiling) ? p + 8'd1 : p;
  endfunction

  // First entry of maximal priority; ties go to the one nearest the head.
  function automatic int best_slot();
    int b;
    b = 0;
    for (int i = 1; i < ready_n; i++)
      if (ready_prio[i] > ready_prio[b]) b = i;
    return b;
  endfunction

  function automatic void append_entry(logic [7:0] id, logic [7:0] prio, logic [7:0] base,
                                       logic [15:0] life, logic [15:0] age);
    ready_id[ready_n]   = id;
    ready_prio[ready_n] = prio;
    ready_base[ready_n] = base;
    ready_life[ready_n] = life;
    ready_age[ready_n]  = age;
    ready_n++;
  endfunction

  // Move entry sel onto the processor, age everyone else, close the gap.
  function automatic void dispatch(int sel);
    cur_valid = 1'b1;
    cur_id    = ready_id[sel];
    cur_base  = ready_base[sel];
    cur_life  = ready_life[sel];
    cur_age   = ready_age[sel];
    for (int i = 0; i < ready_n; i++)
      if (i != sel) ready_prio[i] = bump(ready_prio[i]);
    for (int i = sel; i + 1 < ready_n; i++) begin
      ready_id[i]   = ready_id[i + 1];
      ready_prio[i] = ready_prio[i + 1];
      ready_base[i] = ready_base[i + 1];
      ready_life[i] = ready_life[i + 1];
      ready_age[i]  = ready_age[i + 1];
    end
    ready_n--;
  endfunction

  // Apply one accepted transaction to the shadow state; return the result it
  // should produce.
  function automatic pas_pkg::rsp_t predict_dispatch(pas_pkg::req_t r);
    logic pre;
    logic rej;
    logic alive;
    int   b;
    logic [7:0]  old_id;
    logic [7:0]  old_base;
    logic [15:0] old_life;
    logic [15:0] old_age;
    pas_pkg::rsp_t res;
    pre   = 1'b0;
    rej   = 1'b0;
    alive = 1'b0;
    if (r.operation == pas_pkg::OP_ENQUEUE) begin
      if (ready_n >= QD) rej = 1'b1;
      else append_entry(r.proc_id, r.base_prio, r.base_prio, r.lifespan, r.age_so_far);
    end else begin
      // Blocked with nothing running is simply ignored.
      if (cur_valid && !r.current_blocked) begin
        if (cur_age != 16'hFFFF) cur_age++;
        alive = cur_age < cur_life;
      end
      if (alive) begin
        b = best_slot();
        if (ready_n > 0 && ready_prio[b] >= cur_base) begin
          // Preempt: the chosen entry leaves first, so a full queue never overflows.
          old_id   = cur_id;
          old_base = cur_base;
          old_life = cur_life;
          old_age  = cur_age;
          dispatch(b);
          append_entry(old_id, bump(old_base), old_base, old_life, old_age);
          pre = 1'b1;
        end else begin
          for (int i = 0; i < ready_n; i++) ready_prio[i] = bump(ready_prio[i]);
        end
      end else begin
        // Finished or blocked: drop it, then pick from the queue if anything waits.
        cur_valid = 1'b0;
        cur_id    = 8'd0;
        cur_base  = 8'd0;
        cur_life  = 16'd0;
        cur_age   = 16'd0;
        if (ready_n > 0) dispatch(best_slot());
      end
    end
    res.run_valid = cur_valid;
    res.run_id    = cur_valid ? cur_id : 8'd0;
    res.preempted = pre;
    res.rejected  = rej;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Compare results first, then log the transaction accepted on the same edge,
  // so a result can never be matched against its own request.
  always @(posedge clk) begin
    pas_pkg::rsp_t want;
    pinned_t       pin;
    pas_pkg::rsp_t guess;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (dispatch_q.size() == 0) begin
          fail_count++;
          $error("result with no transaction pending: %h", rsp);
        end else begin
          want = dispatch_q.pop_front();
          check_field("run_valid", want.run_valid, rsp.run_valid);
          check_field("run_id", want.run_id, rsp.run_id);
          check_field("preempted", want.preempted, rsp.preempted);
          check_field("rejected", want.rejected, rsp.rejected);
        end
      end
      if (req_valid && req_ready) begin
        guess = predict_dispatch(req);
        pin   = pinned_q.pop_front();
        dispatch_q.push_back(pin.pinned ? pin.want : guess);
      end
    end
  end

  // Give up after a long stretch in which nothing moves.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stall about 30 % of the time when idling is on; on request, hold
  // off for a long stretch so the block backs up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        rsp_ready <= rsp_idle ? ($urandom_range(99) >= 30) : 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_row(logic op, logic [7:0] id, logic [7:0] prio,
                                  logic [15:0] life, logic [15:0] age, logic blk,
                                  logic pinned, pas_pkg::rsp_t want);
    dir_row_t row;
    row.item.operation       = op;
    row.item.proc_id         = id;
    row.item.base_prio       = prio;
    row.item.lifespan        = life;
    row.item.age_so_far      = age;
    row.item.current_blocked = blk;
    row.pin.pinned           = pinned;
    row.pin.want             = want;
    dir_rows.push_back(row);
  endfunction

  // Mostly small lifespans and ages so processes finish and get preempted
  // often; small priorities give plenty of ties. Full-range values keep every
  // bit of every field moving.
  function automatic pas_pkg::req_t rand_item(int enq_pct);
    pas_pkg::req_t r;
    r.operation       = ($urandom_range(99) < enq_pct) ? pas_pkg::OP_ENQUEUE
                                                       : pas_pkg::OP_TICK;
    r.proc_id         = 8'($urandom);
    r.base_prio       = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8));
    r.lifespan        = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
    r.age_so_far      = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    r.current_blocked = ($urandom_range(99) < 15);
    return r;
  endfunction

  // Offer one transaction and hold it until accepted. Returns at the accepting
  // edge with valid still high, so back-to-back items drop valid only for a random idle gap.
  task automatic push_item(pas_pkg::req_t r, pinned_t pin);
    if (req_idle && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pinned_q.push_back(pin);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent_count++;
  endtask

  // Stop offering and wait until every transaction has produced its result.
  task automatic drain();
    req_valid <= 1'b0;
    while (rsp_seen != sent_count) @(posedge clk);
  endtask

  task automatic set_ceiling(logic [7:0] v);
    cfg_value <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    ceiling = v;
  endtask

  initial begin
    int      enq_pct[6];
    pinned_t no_pin;
    logic [7:0] prio;
    enq_pct = '{60, 50, 70, 40, 55, 50};
    no_pin.pinned = 1'b0;
    no_pin.want   = '0;

    ready_n   = 0;
    cur_valid = 1'b0;
    cur_id    = 8'd0;
    cur_base  = 8'd0;
    cur_life  = 16'd0;
    cur_age   = 16'd0;
    ceiling   = 8'd255;

    // Directed rows at the reset ceiling of 255.
    // Tick with nothing to run, then blocked is ignored with nothing running.
    add_row(pas_pkg::OP_TICK,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1, NOTHING_RUNS);
    add_row(pas_pkg::OP_ENQUEUE, 8'hFF, 8'h00, 16'hFFFF, 16'h0000, 1'b0, 1'b1, NOTHING_RUNS);
    add_row(pas_pkg::OP_TICK,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1, FF_RUNS);
    // Top-priority entry whose age already reaches its lifespan: it preempts,
    // runs for one tick anyway, and is dropped on the next.
    add_row(pas_pkg::OP_ENQUEUE, 8'h00, 8'hFF, 16'h0000, 16'hFFFF, 1'b0, 1'b1, FF_RUNS);
    add_row(pas_pkg::OP_TICK,    8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, ZERO_PREEMPT);
    add_row(pas_pkg::OP_TICK,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1, FF_RUNS);
    // Fill the ready queue; the first entry sits at the ceiling and never ages.
    for (int i = 1; i <= QD; i++) begin
      prio = (i == 1) ? 8'hFF : 8'(i * 13);
      add_row(pas_pkg::OP_ENQUEUE, 8'(i), prio, 16'd3, 16'd0, 1'(i % 2), 1'b1, FF_RUNS);
    end
    // Full queue rejects; preemption on a full queue still fits.
    add_row(pas_pkg::OP_ENQUEUE, 8'hAA, 8'h55, 16'h5555, 16'hAAAA, 1'b0, 1'b1, FF_FULL);
    add_row(pas_pkg::OP_TICK,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1, ONE_PREEMPT);
    add_row(pas_pkg::OP_TICK,    8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, NOTHING_RUNS);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) push_item(dir_rows[k].item, dir_rows[k].pin);

    // Random phases, each at its own ceiling. Drain before every write so the
    // register only changes while the block is idle.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_ceiling(8'd0);
        1: set_ceiling(8'd255);
        2: set_ceiling(8'($urandom_range(2, 253)));
        3: set_ceiling(8'd1);
        4: set_ceiling(8'd254);
        default: set_ceiling(8'($urandom_range(2, 253)));
      endcase
      // Run one phase flat out on both sides.
      req_idle = (ph != 1);
      rsp_idle = (ph != 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Back the block up: hold the receiver off and keep offering items.
        if (ph == 3 && i == 0) hold_rsp = 1'b1;
        if (ph == 3) req_idle = (i >= 40);
        push_item(rand_item(enq_pct[ph]), no_pin);
      end
    end

    drain();
    repeat (QD + 4) @(posedge clk);
    if (dispatch_q.size() != 0) begin
      fail_count++;
      $error("%0d results still outstanding", dispatch_q.size());
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== priority_aging_scheduler.f =====
src/pas_pkg.sv
src/pas_cell.sv
src/priority_aging_scheduler.sv
verif/tb_top.sv
